>>> design/hap_pkg.sv
// Package for the Heron triangle core: default widths, result widths and helpers.
// Depends on nothing; imported by every module of the core.
`timescale 1ns / 1ps
package hap_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int PERIM_BITS     = 19;
    localparam int AREA_BITS      = 28;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction
endpackage

>>> design/hap_sqrt_cell.sv
// One bit cell of the digit-by-digit square root chain.
// Depends on hap_pkg; instantiated in a row by the top level.
`timescale 1ns / 1ps
module hap_sqrt_cell
    import hap_pkg::*;
#(
    parameter int VW  = 33,
    parameter int RW  = 17,
    parameter int BIT = 0
)
(
    input  logic          clk,
    input  logic [VW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    output logic [VW-1:0] rem_out,
    output logic [RW-1:0] root_out
);
    logic [VW-1:0] trial;
    logic          take;
    logic [VW-1:0] rem_next;
    logic [RW-1:0] root_next;

    always_comb
    begin
        trial     = (VW'(root_in) << (BIT + 1)) + (VW'(1) << (2 * BIT));
        take      = (rem_in >= trial);
        rem_next  = take ? (rem_in - trial) : rem_in;
        root_next = take ? (root_in | (RW'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        rem_out  <= rem_next;
        root_out <= root_next;
    end
endmodule

>>> design/triangle_heron_area_perimeter_core.sv
// Top level of the Heron triangle core: side lengths, perimeter and area pipeline.
// Depends on hap_pkg and hap_sqrt_cell.
//
// Channel   Direction  Handshake           Payload
// command   in         start, busy         ax, ay, bx, by_coord, cx, cy
// result    out        done (one cycle)    perim, area_out
//
// One transaction is accepted in every cycle; busy stays low.
// Each transaction passes through one row of square root cells per side, one cell per
// result bit, then the split area multiplier and the row of square root cells for the area.
// Reset clears only the valid pipeline; no result appears until an accepted command
// has passed through. The receiver cannot stall, so the pipeline never stops.
`timescale 1ns / 1ps
module triangle_heron_area_perimeter_core
    import hap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by_coord,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         done,
    output logic [PERIM_BITS-1:0]        perim,
    output logic [AREA_BITS-1:0]         area_out
);
    localparam int C   = COORD_BITS;
    localparam int SVW = 2 * C + 1;
    localparam int SRW = C + 1;
    localparam int PW  = C + 3;
    localparam int SH  = 2 * FRAC_BITS + 4;
    localparam int AVW = max_int(4 * PW - SH, 2 * AREA_BITS + 1);
    localparam int LAT = 2 + SRW + 5 + AREA_BITS;

    logic             accept;
    logic [LAT-1:0]   vld_reg;
    logic [C-1:0]     dx_reg [3];
    logic [C-1:0]     dy_reg [3];
    logic [SVW-1:0]   sq_reg [3];
    logic [SVW-1:0]   sr_rem [3][SRW+1];
    logic [SRW-1:0]   sr_root [3][SRW+1];
    logic [PW-1:0]    s_reg;
    logic [SRW-1:0]   side_reg [3];
    logic [PW-1:0]    f_s_reg;
    logic [PW-1:0]    f_reg [3];
    logic [2*PW-1:0]  p1_reg;
    logic [2*PW-1:0]  p2_reg;
    logic [PW-1:0]    m1_s_reg;
    logic [2*PW-1:0]  pp_reg [4];
    logic [PW-1:0]    m2_s_reg;
    logic [4*PW-1:0]  prod_reg;
    logic [PW-1:0]    m3_s_reg;
    logic [AVW-1:0]   ar_rem [AREA_BITS+1];
    logic [AREA_BITS-1:0] ar_root [AREA_BITS+1];
    logic [PW-1:0]    pd_reg [AREA_BITS];
    logic [C-1:0]     dx_next [3];
    logic [C-1:0]     dy_next [3];
    logic [PW-1:0]    f_next [3];

    function automatic logic [C-1:0] abs_diff(input logic signed [C-1:0] a,
                                              input logic signed [C-1:0] b);
        logic signed [C:0] d;
        logic signed [C:0] m;
        d = {a[C-1], a} - {b[C-1], b};
        m = d[C] ? -d : d;
        return m[C-1:0];
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    always_comb
    begin
        dx_next[0] = abs_diff(ax, bx);
        dy_next[0] = abs_diff(ay, by_coord);
        dx_next[1] = abs_diff(bx, cx);
        dy_next[1] = abs_diff(by_coord, cy);
        dx_next[2] = abs_diff(cx, ax);
        dy_next[2] = abs_diff(cy, ay);
        for (int l = 0; l < 3; l++)
        begin
            f_next[l] = (s_reg > PW'({side_reg[l], 1'b0}))
                        ? (s_reg - PW'({side_reg[l], 1'b0})) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            dx_reg[l]   <= dx_next[l];
            dy_reg[l]   <= dy_next[l];
            sq_reg[l]   <= SVW'(dx_reg[l] * dx_reg[l]) + SVW'(dy_reg[l] * dy_reg[l]);
            side_reg[l] <= sr_root[l][SRW];
            f_reg[l]    <= f_next[l];
        end
        s_reg    <= PW'(sr_root[0][SRW]) + PW'(sr_root[1][SRW]) + PW'(sr_root[2][SRW]);
        f_s_reg  <= s_reg;
        p1_reg   <= f_s_reg * f_reg[0];
        p2_reg   <= f_reg[1] * f_reg[2];
        m1_s_reg <= f_s_reg;
        pp_reg[0] <= p1_reg[PW-1:0] * p2_reg[PW-1:0];
        pp_reg[1] <= p1_reg[PW-1:0] * p2_reg[2*PW-1:PW];
        pp_reg[2] <= p1_reg[2*PW-1:PW] * p2_reg[PW-1:0];
        pp_reg[3] <= p1_reg[2*PW-1:PW] * p2_reg[2*PW-1:PW];
        m2_s_reg <= m1_s_reg;
        prod_reg <= (4*PW)'(pp_reg[0])
                  + (((4*PW)'(pp_reg[1]) + (4*PW)'(pp_reg[2])) << PW)
                  + ((4*PW)'(pp_reg[3]) << (2 * PW));
        m3_s_reg <= m2_s_reg;
        pd_reg[0] <= m3_s_reg;
        for (int k = 1; k < AREA_BITS; k++)
        begin
            pd_reg[k] <= pd_reg[k-1];
        end
    end

    genvar gl, gj;
    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            assign sr_rem[gl][0]  = sq_reg[gl];
            assign sr_root[gl][0] = '0;
            for (gj = 0; gj < SRW; gj++)
            begin : g_cell
                hap_sqrt_cell #(.VW(SVW), .RW(SRW), .BIT(SRW - 1 - gj)) u_cell
                (
                    .clk      (clk),
                    .rem_in   (sr_rem[gl][gj]),
                    .root_in  (sr_root[gl][gj]),
                    .rem_out  (sr_rem[gl][gj+1]),
                    .root_out (sr_root[gl][gj+1])
                );
            end
        end

        assign ar_rem[0]  = AVW'(prod_reg >> SH);
        assign ar_root[0] = '0;
        for (gj = 0; gj < AREA_BITS; gj++)
        begin : g_area
            hap_sqrt_cell #(.VW(AVW), .RW(AREA_BITS), .BIT(AREA_BITS - 1 - gj)) u_cell
            (
                .clk      (clk),
                .rem_in   (ar_rem[gj]),
                .root_in  (ar_root[gj]),
                .rem_out  (ar_rem[gj+1]),
                .root_out (ar_root[gj+1])
            );
        end
    endgenerate

    assign done     = vld_reg[LAT-1];
    assign perim    = PERIM_BITS'(pd_reg[AREA_BITS-1]);
    assign area_out = ar_root[AREA_BITS];

    // A triangle with zero perimeter has all vertices equal, so its area must be zero.
    a_zero_perim_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (pd_reg[AREA_BITS-1] == '0)) |-> (area_out == '0))
        else $error("nonzero area for a zero perimeter transaction");

    // The pipeline takes a transaction in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("command refused while the pipeline streams");
endmodule
